### hw/rtl/i2cms_pkg.sv
// i2cms_pkg: shared types and codes for the i2c master bit sequencer
// no dependencies; used by the channel interface and the top level
`timescale 1ns / 1ps

package i2cms_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_STOP  = 2'd3
    } func_t;

    localparam int unsigned BITS_PER_BYTE = 8;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_received;
    } out_item_t;

endpackage

### hw/rtl/i2cms_chan_if.sv
// i2cms_chan_if: valid/ready channel carrying one payload of type T
// depends on i2cms_pkg for the default payload type
`timescale 1ns / 1ps

interface i2cms_chan_if
    import i2cms_pkg::*;
#(
    parameter type T = in_item_t
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/i2c_master_bit_sequencer_top.sv
// i2c_master_bit_sequencer_top: bit-banged i2c master sequencer
// depends on i2cms_pkg and i2cms_chan_if
`timescale 1ns / 1ps

// Each request on the item channel is one tick of bus time: it carries the
// sampled SDA level and, when cmd_valid is set, a command (start, write byte,
// read byte, stop) that is taken only while the sequencer is idle. Every
// request produces exactly one result holding the SCL level, the SDA pull-down,
// busy/done flags, the last read byte and the last write ack. The sequencer
// advances one step per request in a single pass of logic from the state
// registers into the result register, so a request is taken every clock cycle
// whenever the result register is empty or being drained in the same cycle;
// throughput is one tick per cycle. delay_ticks sets how many ticks each line
// level is held between edges (zero behaves as one); the user must write it
// through cfg_we/cfg_wdata only while no command is running; not enforced by the block.
module i2c_master_bit_sequencer_top
    import i2cms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    i2cms_chan_if.sink           item,
    i2cms_chan_if.source         result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST1  = 4'd1,
        PH_ST2  = 4'd2,
        PH_SP1  = 4'd3,
        PH_SP2  = 4'd4,
        PH_WA   = 4'd5,
        PH_WB   = 4'd6,
        PH_WC   = 4'd7,
        PH_RA   = 4'd8,
        PH_RB   = 4'd9,
        PH_RC   = 4'd10
    } phase_t;

    // configuration
    logic [15:0] delay_ticks_reg;

    // sequencer state
    phase_t      phase_reg,        phase_next;
    logic [3:0]  bit_count_reg,    bit_count_next;
    logic [7:0]  shifter_reg,      shifter_next;
    logic [15:0] delay_count_reg,  delay_count_next;
    logic        scl_level_reg,    scl_level_next;
    logic        sda_level_reg,    sda_level_next;
    logic        ack_flag_reg,     ack_flag_next;
    logic        nack_pending_reg, nack_pending_next;
    logic [7:0]  rx_byte_reg,      rx_byte_next;

    // result register
    out_item_t   res_reg;
    logic        res_valid_reg;

    in_item_t    req;
    logic        accept;
    logic        done;
    logic [15:0] reload;   // delay_ticks - 1, with zero treated as one

    assign req          = item.data;
    // a request is taken when the result slot is free or drains this cycle
    assign item.ready   = !res_valid_reg || result.ready;
    assign accept       = item.valid && item.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;
    assign reload       = (delay_ticks_reg == 16'd0) ? 16'd0 : delay_ticks_reg - 16'd1;

    // one tick of the sequencer
    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shifter_next      = shifter_reg;
        delay_count_next  = delay_count_reg;
        scl_level_next    = scl_level_reg;
        sda_level_next    = sda_level_reg;
        ack_flag_next     = ack_flag_reg;
        nack_pending_next = nack_pending_reg;
        rx_byte_next      = rx_byte_reg;
        done              = 1'b0;

        if (phase_reg == PH_IDLE || phase_reg > PH_RC)
        begin
            // idle: take a command if one is offered
            phase_next = PH_IDLE;
            if (req.cmd_valid)
            begin
                delay_count_next = reload;
                unique case (func_t'(req.func))
                    FUNC_START:
                    begin
                        phase_next     = PH_ST1;
                        scl_level_next = 1'b1;
                        sda_level_next = 1'b1;
                    end
                    FUNC_WRITE:
                    begin
                        shifter_next   = req.data_byte;
                        bit_count_next = 4'd0;
                        phase_next     = PH_WA;
                        scl_level_next = 1'b0;
                    end
                    FUNC_READ:
                    begin
                        shifter_next      = 8'h00;
                        bit_count_next    = 4'd0;
                        nack_pending_next = req.last_byte;
                        phase_next        = PH_RA;
                        scl_level_next    = 1'b0;
                    end
                    default:
                    begin
                        phase_next     = PH_SP1;
                        scl_level_next = 1'b0;
                        sda_level_next = 1'b0;
                    end
                endcase
            end
        end
        else if (delay_count_reg != 16'd0)
        begin
            delay_count_next = delay_count_reg - 16'd1;
        end
        else
        begin
            delay_count_next = reload;
            unique case (phase_reg)
                PH_ST1:
                begin
                    phase_next     = PH_ST2;
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b0;
                end
                PH_ST2:
                begin
                    delay_count_next = delay_count_reg;
                    scl_level_next   = 1'b0;
                    phase_next       = PH_IDLE;
                    done             = 1'b1;
                end
                PH_SP1:
                begin
                    phase_next     = PH_SP2;
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b0;
                end
                PH_SP2:
                begin
                    delay_count_next = delay_count_reg;
                    sda_level_next   = 1'b1;
                    phase_next       = PH_IDLE;
                    done             = 1'b1;
                end
                PH_WA:
                begin
                    phase_next     = PH_WB;
                    scl_level_next = 1'b0;
                    // data bits msb first, released for the ack clock
                    sda_level_next = (bit_count_reg < 4'(BITS_PER_BYTE)) ?
                                     shifter_reg[7] : 1'b1;
                end
                PH_WB:
                begin
                    phase_next     = PH_WC;
                    scl_level_next = 1'b1;
                end
                PH_WC:
                begin
                    if (bit_count_reg < 4'(BITS_PER_BYTE))
                        shifter_next = {shifter_reg[6:0], 1'b0};
                    else
                        ack_flag_next = req.sda_in;
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_reg >= 4'(BITS_PER_BYTE))
                    begin
                        delay_count_next = delay_count_reg;
                        scl_level_next   = 1'b0;
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_next     = PH_WA;
                        scl_level_next = 1'b0;
                    end
                end
                PH_RA:
                begin
                    phase_next     = PH_RB;
                    scl_level_next = 1'b0;
                    // release during data, ack or nack on the ack clock
                    sda_level_next = (bit_count_reg < 4'(BITS_PER_BYTE)) ?
                                     1'b1 : nack_pending_reg;
                end
                PH_RB:
                begin
                    phase_next     = PH_RC;
                    scl_level_next = 1'b1;
                end
                default:
                begin
                    // PH_RC: sample on leaving scl high
                    if (bit_count_reg < 4'(BITS_PER_BYTE))
                        shifter_next = {shifter_reg[6:0], req.sda_in};
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_reg >= 4'(BITS_PER_BYTE))
                    begin
                        delay_count_next = delay_count_reg;
                        rx_byte_next     = shifter_reg;
                        scl_level_next   = 1'b0;
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_next     = PH_RA;
                        scl_level_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg  <= 16'd1;
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            shifter_reg      <= 8'h00;
            delay_count_reg  <= 16'd0;
            scl_level_reg    <= 1'b1;
            sda_level_reg    <= 1'b1;
            ack_flag_reg     <= 1'b0;
            nack_pending_reg <= 1'b0;
            rx_byte_reg      <= 8'h00;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
                delay_ticks_reg <= cfg_wdata;

            if (accept)
            begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                shifter_reg      <= shifter_next;
                delay_count_reg  <= delay_count_next;
                scl_level_reg    <= scl_level_next;
                sda_level_reg    <= sda_level_next;
                ack_flag_reg     <= ack_flag_next;
                nack_pending_reg <= nack_pending_next;
                rx_byte_reg      <= rx_byte_next;
                res_valid_reg    <= 1'b1;

                // result payload for this tick
                res_reg.scl_out       <= scl_level_next;
                res_reg.sda_drive_low <= !sda_level_next;
                res_reg.busy_res      <= (phase_next != PH_IDLE);
                res_reg.done_res      <= done;
                res_reg.read_data     <= rx_byte_next;
                res_reg.ack_received  <= ack_flag_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### dv/i2c_master_bit_sequencer_top_tb.sv
// i2c_master_bit_sequencer_top_tb: self-checking bench for the bit-banged i2c master sequencer
// depends on i2cms_pkg, i2cms_chan_if and i2c_master_bit_sequencer_top
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_top_tb;
    import i2cms_pkg::*;

    localparam int unsigned CLOCKS_PER_BYTE = BITS_PER_BYTE + 1;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam int unsigned RANDOM_TICKS    = 1000;

    // sequencer phases as tracked by the line predictor
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START_HI,
        SEQ_START_LO,
        SEQ_STOP_LO,
        SEQ_STOP_HI,
        SEQ_WR_LOW,
        SEQ_WR_DATA,
        SEQ_WR_HIGH,
        SEQ_RD_LOW,
        SEQ_RD_DATA,
        SEQ_RD_HIGH
    } seq_phase_t;

    // how the sampled sda level is chosen for each tick
    typedef enum logic [1:0] {
        SDA_RANDOM,
        SDA_HIGH,
        SDA_LOW
    } sda_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2cms_chan_if #(.T(in_item_t))  item_if ();
    i2cms_chan_if #(.T(out_item_t)) result_if ();

    i2c_master_bit_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_if),
        .result    (result_if)
    );

    always #5 clk = ~clk;

    // predictor state, starts at the reset values
    logic [15:0] delay_cfg    = 16'd1;
    seq_phase_t  seq_phase    = SEQ_IDLE;
    logic [3:0]  bits_done    = '0;
    logic [7:0]  byte_shift   = '0;
    logic [15:0] hold_count   = '0;
    logic        scl_q        = 1'b1;
    logic        sda_q        = 1'b1;
    logic        ack_bit      = 1'b0;
    logic        nack_on_last = 1'b0;
    logic [7:0]  rx_byte_q    = '0;

    // expected line states, one per accepted tick, oldest first
    out_item_t   expected_lines[$];

    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned ticks_sent      = 0;
    int unsigned cycle_count     = 0;

    // stimulus knobs
    logic        src_idling    = 1'b1;
    logic        sink_idling   = 1'b1;
    logic        hold_off_req  = 1'b0;
    sda_mode_t   sda_mode      = SDA_RANDOM;
    int unsigned busy_noise    = 0;

    // ---------------------------------------------------------------
    // line predictor
    // ---------------------------------------------------------------

    // enter a segment: set both lines and arm the hold counter
    function automatic void load_segment(seq_phase_t ph, logic scl, logic sda);
        seq_phase  = ph;
        scl_q      = scl;
        sda_q      = sda;
        hold_count = (delay_cfg == 16'd0) ? 16'd0 : delay_cfg - 16'd1;
    endfunction

    // one bus tick: advance the sequencer and return the resulting line state
    function automatic out_item_t advance_bus_tick(in_item_t it);
        out_item_t r;
        logic      done;
        done = 1'b0;
        if (seq_phase == SEQ_IDLE) begin
            // commands are only taken while idle
            if (it.cmd_valid) begin
                case (it.func)
                    FUNC_START: load_segment(SEQ_START_HI, 1'b1, 1'b1);
                    FUNC_WRITE:
                    begin
                        byte_shift = it.data_byte;
                        bits_done  = '0;
                        load_segment(SEQ_WR_LOW, 1'b0, sda_q);
                    end
                    FUNC_READ:
                    begin
                        byte_shift   = '0;
                        bits_done    = '0;
                        nack_on_last = it.last_byte;
                        load_segment(SEQ_RD_LOW, 1'b0, sda_q);
                    end
                    default: load_segment(SEQ_STOP_LO, 1'b0, 1'b0);
                endcase
            end
        end else if (hold_count != 16'd0) begin
            hold_count = hold_count - 16'd1;
        end else begin
            case (seq_phase)
                SEQ_START_HI: load_segment(SEQ_START_LO, 1'b1, 1'b0);
                SEQ_START_LO:
                begin
                    scl_q     = 1'b0;
                    seq_phase = SEQ_IDLE;
                    done      = 1'b1;
                end
                SEQ_STOP_LO: load_segment(SEQ_STOP_HI, 1'b1, 1'b0);
                SEQ_STOP_HI:
                begin
                    sda_q     = 1'b1;
                    seq_phase = SEQ_IDLE;
                    done      = 1'b1;
                end
                // the ack clock of a write releases sda for the slave ack
                SEQ_WR_LOW:
                    load_segment(SEQ_WR_DATA, 1'b0,
                                 (bits_done < BITS_PER_BYTE) ? byte_shift[7] : 1'b1);
                SEQ_WR_DATA: load_segment(SEQ_WR_HIGH, 1'b1, sda_q);
                SEQ_WR_HIGH:
                begin
                    if (bits_done < BITS_PER_BYTE)
                        byte_shift = byte_shift << 1;
                    else
                        ack_bit = it.sda_in;
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= CLOCKS_PER_BYTE) begin
                        scl_q     = 1'b0;
                        seq_phase = SEQ_IDLE;
                        done      = 1'b1;
                    end else begin
                        load_segment(SEQ_WR_LOW, 1'b0, sda_q);
                    end
                end
                // the ack clock of a read drives ack low or leaves nack released
                SEQ_RD_LOW:
                    load_segment(SEQ_RD_DATA, 1'b0,
                                 (bits_done < BITS_PER_BYTE) ? 1'b1 : nack_on_last);
                SEQ_RD_DATA: load_segment(SEQ_RD_HIGH, 1'b1, sda_q);
                SEQ_RD_HIGH:
                begin
                    if (bits_done < BITS_PER_BYTE)
                        byte_shift = {byte_shift[6:0], it.sda_in};
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= CLOCKS_PER_BYTE) begin
                        rx_byte_q = byte_shift;
                        scl_q     = 1'b0;
                        seq_phase = SEQ_IDLE;
                        done      = 1'b1;
                    end else begin
                        load_segment(SEQ_RD_LOW, 1'b0, sda_q);
                    end
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end
        r.scl_out       = scl_q;
        r.sda_drive_low = ~sda_q;
        r.busy_res      = (seq_phase != SEQ_IDLE);
        r.done_res      = done;
        r.read_data     = rx_byte_q;
        r.ack_received  = ack_bit;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // tick builders
    // ---------------------------------------------------------------

    function automatic logic pick_sda();
        case (sda_mode)
            SDA_HIGH: return 1'b1;
            SDA_LOW:  return 1'b0;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // no command, junk in the ignored fields
    function automatic in_item_t empty_tick();
        in_item_t it;
        it.cmd_valid = 1'b0;
        it.func      = 2'($urandom_range(0, 3));
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'($urandom_range(0, 1));
        it.sda_in    = pick_sda();
        return it;
    endfunction

    function automatic in_item_t cmd_tick(func_t f, logic [7:0] d, logic last_b);
        in_item_t it;
        it.cmd_valid = 1'b1;
        it.func      = f;
        it.data_byte = d;
        it.last_byte = last_b;
        it.sda_in    = pick_sda();
        return it;
    endfunction

    // any command at all, used as noise
    function automatic in_item_t stray_cmd_tick();
        return cmd_tick(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endfunction

    // ---------------------------------------------------------------
    // request driver, always entered and left at a rising clock
    // ---------------------------------------------------------------

    task automatic send_tick(in_item_t it);
        // while src_idling, one request in ten is preceded by a random gap with valid low
        if (src_idling && $urandom_range(0, 9) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        // handshake seen at the falling clock is taken at the next rising one
        do @(negedge clk); while (!item_if.ready);
        expected_lines.push_back(advance_bus_tick(it));
        ticks_sent++;
        @(posedge clk);
    endtask

    // stop offering and wait for every expected line state to come back
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_lines.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // run empty ticks until the sequencer is idle, then drain
    task automatic settle_idle();
        while (seq_phase != SEQ_IDLE) send_tick(empty_tick());
        wait_drained();
    endtask

    // delay register may only change while nothing runs
    task automatic write_delay(logic [15:0] v);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delay_cfg = v;
    endtask

    // issue one command once idle, then tick until it has finished;
    // busy ticks may carry stray commands that must be ignored
    task automatic run_command(func_t f, logic [7:0] d, logic last_b);
        while (seq_phase != SEQ_IDLE) send_tick(empty_tick());
        send_tick(cmd_tick(f, d, last_b));
        while (seq_phase != SEQ_IDLE) begin
            if ($urandom_range(1, 100) <= busy_noise)
                send_tick(stray_cmd_tick());
            else
                send_tick(empty_tick());
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // sink ready: random stall bursts, plus a long hold-off on request
    initial begin : result_drain
        int unsigned stall;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (sink_idling && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(1, 13);
                result_if.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // compare each accepted result with the oldest expected line state
    always @(negedge clk) begin : result_check
        out_item_t want;
        out_item_t got;
        if (rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (expected_lines.size() == 0) begin
                $error("result: expected none, actual %0h", got);
                error_count++;
            end else begin
                want = expected_lines.pop_front();
                results_checked++;
                check_field("scl_out", want.scl_out, got.scl_out);
                check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_received", want.ack_received, got.ack_received);
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("i2c_master_bit_sequencer_top_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset delay of one: all four commands with extreme bytes and sda levels
    task automatic test_reset_delay();
        repeat (3) send_tick(empty_tick());
        run_command(FUNC_START, 8'h00, 1'b0);
        sda_mode = SDA_HIGH;                       // slave nacks
        run_command(FUNC_WRITE, 8'hFF, 1'b1);
        sda_mode = SDA_LOW;                        // slave acks
        run_command(FUNC_WRITE, 8'h00, 1'b0);
        sda_mode = SDA_HIGH;                       // reads all ones, master acks
        run_command(FUNC_READ, 8'h00, 1'b0);
        sda_mode = SDA_LOW;                        // reads all zeros, master nacks
        run_command(FUNC_READ, 8'hFF, 1'b1);
        sda_mode = SDA_RANDOM;
        run_command(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // every busy tick carries a stray command that must be dropped
    task automatic test_ignored_while_busy();
        busy_noise = 100;
        run_command(FUNC_START, 8'h3C, 1'b1);
        run_command(FUNC_WRITE, 8'hA5, 1'b0);
        run_command(FUNC_READ, 8'h5A, 1'b0);
        run_command(FUNC_STOP, 8'hC3, 1'b1);
        busy_noise = 0;
    endtask

    // delay of zero acts as one; a long delay on a start condition
    task automatic test_delay_extremes();
        write_delay(16'h0000);
        run_command(FUNC_START, 8'h00, 1'b0);
        run_command(FUNC_WRITE, 8'h5A, 1'b0);
        run_command(FUNC_STOP, 8'h00, 1'b0);
        write_delay(16'd60);
        run_command(FUNC_START, 8'h00, 1'b0);
        write_delay(16'd2);
        run_command(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // long sink hold-off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_delay(16'd1);
        hold_off_req = 1'b1;
        run_command(FUNC_START, 8'h00, 1'b0);
        run_command(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        run_command(FUNC_READ, 8'h00, 1'($urandom_range(0, 1)));
    endtask

    // sender stops mid-transfer until every result is back
    task automatic test_sender_pause();
        run_command(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        wait_drained();
        run_command(FUNC_READ, 8'h00, 1'b1);
        wait_drained();
        run_command(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // one transfer: mostly well formed, sometimes stray or broken requests
    task automatic random_transaction();
        int unsigned nbytes;
        busy_noise = ($urandom_range(0, 3) == 0) ? 20 : 0;
        if ($urandom_range(0, 9) < 8) begin
            repeat ($urandom_range(0, 2)) send_tick(empty_tick());
            run_command(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            nbytes = $urandom_range(1, 4);
            for (int unsigned i = 0; i < nbytes; i++) begin
                repeat ($urandom_range(0, 2)) send_tick(empty_tick());
                if ($urandom_range(0, 1))
                    run_command(FUNC_WRITE, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
                else
                    run_command(FUNC_READ, 8'($urandom_range(0, 255)),
                                (i == nbytes - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            end
            run_command(FUNC_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            // stray commands at arbitrary times, including mid-command
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1))
                    send_tick(stray_cmd_tick());
                else
                    send_tick(empty_tick());
            end
        end
    endtask

    // random traffic over several delay settings, the last one without idling
    task automatic test_random_traffic(int unsigned tick_budget);
        logic [15:0] delays[6];
        int unsigned stop_at;
        delays = '{16'd1, 16'd2, 16'd3, 16'($urandom_range(1, 6)), 16'd0, 16'd1};
        for (int p = 0; p < 6; p++) begin
            write_delay(delays[p]);
            if (p == 5) begin
                src_idling  = 1'b0;
                sink_idling = 1'b0;
            end
            stop_at = ticks_sent + tick_budget / 6;
            while (ticks_sent < stop_at) random_transaction();
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin : stimulus
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_delay();
        test_ignored_while_busy();
        test_delay_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(RANDOM_TICKS);

        wait_drained();
        repeat (4) @(posedge clk);

        $display("covered %0d bus ticks and %0d checked results over delays 0 to 60,",
                 ticks_sent, results_checked);
        $display("start/write/read/stop with stray commands and stalls on both sides");
        if (error_count == 0)
            $display("i2c_master_bit_sequencer_top_tb: clean");
        else
            $display("i2c_master_bit_sequencer_top_tb: errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_chan_if.sv
hw/rtl/i2c_master_bit_sequencer_top.sv
dv/i2c_master_bit_sequencer_top_tb.sv
